/* rtl/gpsr_pkg.sv */
// Package for the game pad serial responder.
// Holds the item type, command codes, reply constants and template tables.
// No dependencies; used by gpsr_core and game_pad_serial_responder.
package gpsr_pkg;

    localparam int BUFFER_BYTES = 20;
    localparam int PAD_COUNT    = 2;
    localparam int BUF_IDX_W    = $clog2(BUFFER_BYTES);
    localparam int PAD_IDX_W    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_EXCHANGE = 1'b1;

    localparam logic [7:0] CMD_INIT_PRESSURE = 8'h40;
    localparam logic [7:0] CMD_BUTTON_MASK   = 8'h41;
    localparam logic [7:0] CMD_POLL          = 8'h42;
    localparam logic [7:0] CMD_CONFIG        = 8'h43;
    localparam logic [7:0] CMD_SET_MODE      = 8'h44;
    localparam logic [7:0] CMD_QUERY_MODEL   = 8'h45;
    localparam logic [7:0] CMD_QUERY_ACT     = 8'h46;
    localparam logic [7:0] CMD_QUERY_COMB    = 8'h47;
    localparam logic [7:0] CMD_QUERY_MODE    = 8'h4c;
    localparam logic [7:0] CMD_VIB_MAP       = 8'h4d;
    localparam logic [7:0] CMD_PRESSURE_CFG  = 8'h4f;

    localparam logic [7:0] BYTE_CONFIG_REPLY = 8'hf3;
    localparam logic [7:0] BYTE_ACK          = 8'h5a;
    localparam logic [7:0] BYTE_IDLE         = 8'hff;
    localparam logic [7:0] ID_DIGITAL        = 8'h41;
    localparam logic [7:0] ID_ANALOG         = 8'h73;
    localparam logic [7:0] ID_PRESSURE       = 8'h79;
    localparam logic [7:0] ACT_FAST_BYTE     = 8'h14;
    localparam logic [7:0] ACT_SLOW_BYTE     = 8'h0a;
    localparam logic [4:0] TEMPLATE_LENGTH   = 5'd8;

    typedef struct packed {
        logic        func;
        logic        pad_select;
        logic        frame_start;
        logic [7:0]  tx_byte;
        logic [15:0] buttons;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
    } item_t;

    typedef logic [7:0][7:0] row_t;

    // Reply template for a configuration command; byte 0 is element 0.
    function automatic row_t template_row(input logic [7:0] cmd);
        row_t row;
        case (cmd)
            CMD_INIT_PRESSURE: row = 64'h5a000002_00005aff;
            CMD_BUTTON_MASK:   row = 64'h5a000003_ffff5aff;
            CMD_QUERY_MODEL:   row = 64'h00010201_02005aff;
            CMD_QUERY_ACT:     row = 64'h0a000201_00005aff;
            CMD_QUERY_COMB:    row = 64'h00010002_00005aff;
            CMD_VIB_MAP:       row = 64'hffffffff_ffff5aff;
            CMD_PRESSURE_CFG:  row = 64'h5a000000_00005aff;
            default:           row = 64'h00000000_00005aff;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] motor_map_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = 8'h04;
            2'd1:    b = 8'h07;
            2'd2:    b = 8'h02;
            default: b = 8'h05;
        endcase
        return b;
    endfunction

endpackage

/* rtl/gpsr_core.sv */
// Command decode and pad state for the game pad serial responder.
// Holds the reply buffer, frame counter and per-pad state; computes one reply per exchange item.
// Depends on gpsr_pkg.
module gpsr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  gpsr_pkg::item_t     item,
    output logic [7:0]          rx_byte
);

    logic [7:0] buf_reg  [gpsr_pkg::BUFFER_BYTES];
    logic [7:0] buf_next [gpsr_pkg::BUFFER_BYTES];
    logic [4:0] idx_reg, idx_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [4:0] len_reg, len_next;
    logic [7:0] pad_id_reg  [gpsr_pkg::PAD_COUNT];
    logic [7:0] pad_id_next [gpsr_pkg::PAD_COUNT];
    logic       analog_reg  [gpsr_pkg::PAD_COUNT];
    logic       analog_next [gpsr_pkg::PAD_COUNT];
    logic       cfg_reg     [gpsr_pkg::PAD_COUNT];
    logic       cfg_next    [gpsr_pkg::PAD_COUNT];
    logic [4:0] small_reg   [gpsr_pkg::PAD_COUNT];
    logic [4:0] small_next  [gpsr_pkg::PAD_COUNT];
    logic [4:0] large_reg   [gpsr_pkg::PAD_COUNT];
    logic [4:0] large_next  [gpsr_pkg::PAD_COUNT];

    logic [gpsr_pkg::PAD_IDX_W-1:0] p;
    logic [4:0]      cur;
    logic            decoded;
    logic            raise;
    logic [5:0]      poll_len;
    logic [4:0]      cur_m1;
    logic [3:0]      id_len_n;
    gpsr_pkg::row_t  row;

    assign p = (int'(item.pad_select) < gpsr_pkg::PAD_COUNT) ?
               gpsr_pkg::PAD_IDX_W'(item.pad_select) : '0;
    assign row      = gpsr_pkg::template_row(item.tx_byte);
    assign poll_len = 6'd2 + {1'b0, pad_id_reg[p][3:0], 1'b0};

    always_comb begin
        buf_next    = buf_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        pad_id_next = pad_id_reg;
        analog_next = analog_reg;
        cfg_next    = cfg_reg;
        small_next  = small_reg;
        large_next  = large_reg;
        rx_byte     = gpsr_pkg::BYTE_IDLE;
        decoded     = 1'b0;
        raise       = 1'b0;
        cur         = item.frame_start ? 5'd0 : idx_reg;
        cur_m1      = cur - 5'd1;
        id_len_n    = cur_m1[4:1];
        if (go) begin
            if (item.func == gpsr_pkg::FUNC_LOAD) begin
                buf_next[2] = item.buttons[7:0];
                buf_next[3] = item.buttons[15:8];
                buf_next[4] = item.right_x;
                buf_next[5] = item.right_y;
                buf_next[6] = item.left_x;
                buf_next[7] = item.left_y;
            end else begin
                idx_next = cur;
                if (cur == 5'd0) begin
                    idx_next = 5'd1;
                    cmd_next = item.tx_byte;
                    case (item.tx_byte)
                        gpsr_pkg::CMD_INIT_PRESSURE, gpsr_pkg::CMD_BUTTON_MASK,
                        gpsr_pkg::CMD_SET_MODE, gpsr_pkg::CMD_QUERY_MODEL,
                        gpsr_pkg::CMD_QUERY_ACT, gpsr_pkg::CMD_QUERY_COMB,
                        gpsr_pkg::CMD_QUERY_MODE, gpsr_pkg::CMD_VIB_MAP,
                        gpsr_pkg::CMD_PRESSURE_CFG: begin
                            for (int i = 0; i < 8; i++) begin
                                buf_next[i] = row[i];
                            end
                            len_next = gpsr_pkg::TEMPLATE_LENGTH;
                            rx_byte  = gpsr_pkg::BYTE_CONFIG_REPLY;
                            decoded  = 1'b1;
                            if (item.tx_byte == gpsr_pkg::CMD_QUERY_MODEL) begin
                                buf_next[4] = {7'd0, analog_reg[p]};
                            end
                            if (item.tx_byte == gpsr_pkg::CMD_PRESSURE_CFG) begin
                                pad_id_next[p] = gpsr_pkg::ID_PRESSURE;
                            end
                        end
                        gpsr_pkg::CMD_POLL, gpsr_pkg::CMD_CONFIG: begin
                            len_next    = (poll_len > 6'd31) ? 5'd31 : poll_len[4:0];
                            buf_next[1] = gpsr_pkg::BYTE_ACK;
                            decoded     = 1'b1;
                            if (item.tx_byte == gpsr_pkg::CMD_CONFIG && cfg_reg[p]) begin
                                buf_next[4] = 8'h00;
                                buf_next[5] = 8'h00;
                                buf_next[6] = 8'h00;
                                buf_next[7] = 8'h00;
                                rx_byte     = gpsr_pkg::BYTE_CONFIG_REPLY;
                            end else begin
                                rx_byte = pad_id_reg[p];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (!decoded) begin
                    case (cmd_next)
                        gpsr_pkg::CMD_CONFIG: begin
                            if (cur == 5'd2) begin
                                cfg_next[p] = (item.tx_byte != 8'h00);
                            end
                        end
                        gpsr_pkg::CMD_SET_MODE: begin
                            if (cur == 5'd2) begin
                                analog_next[p] = (item.tx_byte != 8'h00);
                                small_next[p]  = 5'd0;
                                large_next[p]  = 5'd0;
                                pad_id_next[p] = (item.tx_byte != 8'h00) ?
                                                 gpsr_pkg::ID_ANALOG : gpsr_pkg::ID_DIGITAL;
                            end
                        end
                        gpsr_pkg::CMD_QUERY_ACT: begin
                            if (cur == 5'd2 && item.tx_byte == 8'h00) begin
                                buf_next[5] = 8'h02;
                                buf_next[6] = 8'h00;
                                buf_next[7] = gpsr_pkg::ACT_SLOW_BYTE;
                            end else if (cur == 5'd2 && item.tx_byte == 8'h01) begin
                                buf_next[5] = 8'h01;
                                buf_next[6] = 8'h01;
                                buf_next[7] = gpsr_pkg::ACT_FAST_BYTE;
                            end
                        end
                        gpsr_pkg::CMD_QUERY_MODE: begin
                            if (cur == 5'd2) begin
                                buf_next[5] = gpsr_pkg::motor_map_byte(item.tx_byte[1:0]);
                            end
                        end
                        gpsr_pkg::CMD_VIB_MAP: begin
                            if (cur >= 5'd2) begin
                                if (cur == small_reg[p] && int'(cur) < gpsr_pkg::BUFFER_BYTES)
                                begin
                                    buf_next[cur[gpsr_pkg::BUF_IDX_W-1:0]] = 8'h00;
                                end
                                if (cur == large_reg[p] && int'(cur) < gpsr_pkg::BUFFER_BYTES)
                                begin
                                    buf_next[cur[gpsr_pkg::BUF_IDX_W-1:0]] = 8'h01;
                                end
                                if (item.tx_byte == 8'h00) begin
                                    small_next[p] = cur;
                                    raise         = 1'b1;
                                end else if (item.tx_byte == 8'h01) begin
                                    large_next[p] = cur;
                                    raise         = 1'b1;
                                end
                                if (raise && pad_id_reg[p][3:0] < id_len_n) begin
                                    pad_id_next[p] = {pad_id_reg[p][7:4], id_len_n};
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (cur < len_next) begin
                        if (int'(idx_next) < gpsr_pkg::BUFFER_BYTES) begin
                            rx_byte = buf_next[idx_next[gpsr_pkg::BUF_IDX_W-1:0]];
                        end
                        idx_next = idx_next + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cmd_reg <= '0;
            len_reg <= '0;
            for (int i = 0; i < gpsr_pkg::BUFFER_BYTES; i++) begin
                buf_reg[i] <= '0;
            end
            for (int i = 0; i < gpsr_pkg::PAD_COUNT; i++) begin
                pad_id_reg[i] <= gpsr_pkg::ID_DIGITAL;
                analog_reg[i] <= 1'b0;
                cfg_reg[i]    <= 1'b0;
                small_reg[i]  <= '0;
                large_reg[i]  <= '0;
            end
        end else begin
            idx_reg    <= idx_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            buf_reg    <= buf_next;
            pad_id_reg <= pad_id_next;
            analog_reg <= analog_next;
            cfg_reg    <= cfg_next;
            small_reg  <= small_next;
            large_reg  <= large_next;
        end
    end

endmodule

/* rtl/game_pad_serial_responder.sv */
// Top level of the game pad serial responder: input register, core, result register.
// Depends on gpsr_pkg and gpsr_core.
// m_tvalid rises when the result register takes the reply to an exchange item.
// One item per cycle unless a result waits; decode and read fit between two registers.
// A waiting result holds an exchange item in the input register and stalls the input.
// Reset (aresetn low, synchronous) clears both channels, the reply buffer and all pad state.
module game_pad_serial_responder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // tx_byte, buttons, right_x, right_y, left_x, left_y
    input  logic [2:0]  s_tuser,  // func, pad_select, frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // rx_byte
);

    logic            in_valid_reg;
    gpsr_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            core_go;
    logic [7:0]      core_byte;
    gpsr_pkg::item_t s_item;

    assign s_item.func        = s_tuser[0];
    assign s_item.pad_select  = s_tuser[1];
    assign s_item.frame_start = s_tuser[2];
    assign s_item.tx_byte     = s_tdata[7:0];
    assign s_item.buttons     = s_tdata[23:8];
    assign s_item.right_x     = s_tdata[31:24];
    assign s_item.right_y     = s_tdata[39:32];
    assign s_item.left_x      = s_tdata[47:40];
    assign s_item.left_y      = s_tdata[55:48];

    assign core_go  = in_valid_reg &&
                      (in_item_reg.func == gpsr_pkg::FUNC_LOAD || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || core_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    gpsr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (core_go),
        .item    (in_item_reg),
        .rx_byte (core_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (core_go && in_item_reg.func == gpsr_pkg::FUNC_EXCHANGE) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (core_go && in_item_reg.func == gpsr_pkg::FUNC_EXCHANGE) begin
            out_byte_reg <= core_byte;
        end
    end

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !core_go |=> in_valid_reg)
        else $error("Input item lost while the core was stalled.");

    a_exchange_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        core_go && in_item_reg.func == gpsr_pkg::FUNC_EXCHANGE |=> m_tvalid)
        else $error("Exchange item produced no result.");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        core_go && in_item_reg.func == gpsr_pkg::FUNC_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("Load item produced a result.");

    a_blocked_exchange_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_item_reg.func == gpsr_pkg::FUNC_EXCHANGE &&
        m_tvalid && !m_tready |-> !s_tready)
        else $error("New item accepted while the held exchange item was blocked.");

endmodule
